[rtl/ipid_pkg.sv]
// ---------------------------------------------------------------------------
// ipid_pkg: shared definitions for the incremental PID core
// Loop count, arithmetic widths, register indexes and the result record.
// ---------------------------------------------------------------------------
package ipid_pkg;

   // Number of control loops and the fraction length of the gains.
   localparam int LOOPS          = 8;
   localparam int GAIN_FRAC_BITS = 10;

   localparam int LOOP_W = (LOOPS > 1) ? $clog2(LOOPS) : 1;

   // Field and datapath widths.
   localparam int IDX_W   = 3;
   localparam int SMP_W   = 16;
   localparam int GAIN_W  = 20;
   localparam int LIM_W   = 15;
   localparam int BAND_W  = 16;
   localparam int E_W     = 17;             // setpoint - measured
   localparam int DP_W    = 18;             // e - e1
   localparam int DD_W    = 19;             // e - 2*e1 + e2
   localparam int PP_W    = GAIN_W + DP_W;
   localparam int PI_W    = GAIN_W + E_W;
   localparam int PD_W    = GAIN_W + DD_W;
   localparam int SUM_W   = PD_W + 2;
   localparam int INC_W   = SUM_W - GAIN_FRAC_BITS;
   localparam int D_W     = INC_W + 1;
   localparam int ERR_MEM_W = 2 * E_W;

   // Result buffer depth; a power of two so that the pointers wrap freely.
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_ADDR_W = 3;
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN     = 3'd0,
      CSR_INTEGRAL_GAIN = 3'd1,
      CSR_DERIV_GAIN    = 3'd2,
      CSR_DRIVE_LIMIT   = 3'd3,
      CSR_INTEGRAL_BAND = 3'd4
   } ipid_csr_type;

   localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST   = LIM_W'(2000);
   localparam logic [BAND_W-1:0] INTEGRAL_BAND_RST = BAND_W'(35);

   // One result record as it waits in the output buffer.
   typedef struct packed {
      logic signed [SMP_W-1:0] drive;
      logic                    clamped;
   } ipid_rsp_type;

   // Loop number modulo LOOPS, by repeated subtraction on a narrow value.
   function automatic logic [LOOP_W-1:0] loop_of(input logic [IDX_W-1:0] idx);
      logic [6:0] v;
      v = {4'b0000, idx};
      for (int k = 0; k < 8; k++) begin
         if (v >= 7'(LOOPS)) begin
            v = v - 7'(LOOPS);
         end
      end
      return LOOP_W'(v);
   endfunction

endpackage

[rtl/ipid_ram.sv]
// ---------------------------------------------------------------------------
// ipid_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read; a read of the
// entry written at the same edge returns the old contents.
// ---------------------------------------------------------------------------
module ipid_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ipid_rsp_fifo.sv]
// ---------------------------------------------------------------------------
// ipid_rsp_fifo: result buffer in front of the response channel
// Small register FIFO; its head drives the response port directly.
// ---------------------------------------------------------------------------
module ipid_rsp_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  ipid_pkg::ipid_rsp_type           push_data,
   input  logic                             pop,
   output logic                             head_valid,
   output ipid_pkg::ipid_rsp_type           head_data,
   output logic [ipid_pkg::RSP_CNT_W-1:0]   count
);

   ipid_pkg::ipid_rsp_type                entry_ff [ipid_pkg::RSP_DEPTH];
   logic [ipid_pkg::RSP_PTR_W-1:0]        wr_ptr_ff;
   logic [ipid_pkg::RSP_PTR_W-1:0]        rd_ptr_ff;
   logic [ipid_pkg::RSP_CNT_W-1:0]        count_ff;
   logic [ipid_pkg::RSP_CNT_W-1:0]        count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

[rtl/incremental_pid_integral_separation_core.sv]
// ---------------------------------------------------------------------------
// incremental_pid_integral_separation_core: multi-loop incremental PID
// A result transaction is offered from the output buffer once its request has passed S1 to S4.
// Throughput: one request per cycle while req_tready is high, set by the single write port
// of each of the error and drive RAMs, with one-entry forwarding in front of each.
// Reset (synchronous, active high) zeroes every loop's history and drive,
// clears the gains and sets drive_limit to 2000 and integral_band to 35.
// ---------------------------------------------------------------------------
//
// Pipeline:
//   S0  request edge: error e = setpoint - measured, integral band check,
//       error RAM read issued for the loop.
//   S1  last two errors arrive (forwarded from the previous transaction when
//       it touched the same loop), error RAM written back with {e1, e}, the
//       proportional and derivative differences are formed.
//   S2  the three gain multiplications.
//   S3  sum of products, truncation toward zero, drive RAM read issued.
//   S4  drive arrives (forwarded when needed), increment added, clamp,
//       drive RAM written back, result pushed into the output buffer.
//
// The pipeline never stalls. A request is taken only while the transactions
// in flight plus those waiting in the output buffer leave a free buffer slot,
// so a back-pressured response channel fills the buffer and then closes
// req_tready without any effect on items already in the pipeline.
//
// Both RAMs hold undefined data after reset; a valid flag per loop stands in
// for the zero reset value until the loop's entry is first written.
module incremental_pid_integral_separation_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,  // setpoint[15:0], measured[31:16]
   input  logic [2:0]                           req_tuser,  // loop_index[2:0]
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,  // drive[15:0]
   output logic [0:0]                           rsp_tuser,  // clamped[0]
   // configuration write port
   input  logic                                 csr_we,
   input  logic [ipid_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ipid_pkg::GAIN_W-1:0]          csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [ipid_pkg::GAIN_W-1:0] prop_gain_ff;
   logic signed [ipid_pkg::GAIN_W-1:0] integral_gain_ff;
   logic signed [ipid_pkg::GAIN_W-1:0] deriv_gain_ff;
   logic [ipid_pkg::LIM_W-1:0]         drive_limit_ff;
   logic [ipid_pkg::BAND_W-1:0]        integral_band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integral_gain_ff <= '0;
         deriv_gain_ff    <= '0;
         drive_limit_ff   <= ipid_pkg::DRIVE_LIMIT_RST;
         integral_band_ff <= ipid_pkg::INTEGRAL_BAND_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            ipid_pkg::CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata;
            ipid_pkg::CSR_INTEGRAL_GAIN: integral_gain_ff <= csr_wdata;
            ipid_pkg::CSR_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata;
            ipid_pkg::CSR_DRIVE_LIMIT:   drive_limit_ff   <= csr_wdata[ipid_pkg::LIM_W-1:0];
            ipid_pkg::CSR_INTEGRAL_BAND: integral_band_ff <= csr_wdata[ipid_pkg::BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control
   // ------------------------------------------------------------------
   logic                                 s1_vld_ff;
   logic                                 s2_vld_ff;
   logic                                 s3_vld_ff;
   logic                                 s4_vld_ff;
   logic [ipid_pkg::RSP_CNT_W-1:0]       fifo_count;
   logic [ipid_pkg::RSP_CNT_W:0]         inflight;
   logic                                 req_fire;

   assign inflight = (ipid_pkg::RSP_CNT_W + 1)'(fifo_count)
                   + (ipid_pkg::RSP_CNT_W + 1)'(s1_vld_ff)
                   + (ipid_pkg::RSP_CNT_W + 1)'(s2_vld_ff)
                   + (ipid_pkg::RSP_CNT_W + 1)'(s3_vld_ff)
                   + (ipid_pkg::RSP_CNT_W + 1)'(s4_vld_ff);

   assign req_tready = (inflight < (ipid_pkg::RSP_CNT_W + 1)'(ipid_pkg::RSP_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // S0: error and integral band check on the incoming transaction
   // ------------------------------------------------------------------
   logic [ipid_pkg::LOOP_W-1:0]      s0_loop;
   logic signed [ipid_pkg::E_W-1:0]  s0_err;
   logic [ipid_pkg::E_W-1:0]         s0_mag;
   logic                             s0_int_en;

   assign s0_loop   = ipid_pkg::loop_of(req_tuser);
   assign s0_err    = {req_tdata[15], req_tdata[15:0]} - {req_tdata[31], req_tdata[31:16]};
   assign s0_mag    = s0_err[ipid_pkg::E_W-1] ? ipid_pkg::E_W'(~s0_err + 1'b1) : s0_err;
   assign s0_int_en = (s0_mag <= {1'b0, integral_band_ff});

   // Per-loop written flags stand in for the zero reset of both RAMs.
   logic [ipid_pkg::LOOPS-1:0]       err_written_ff;
   logic [ipid_pkg::LOOPS-1:0]       drv_written_ff;

   logic [ipid_pkg::LOOP_W-1:0]      s1_loop_ff;
   logic signed [ipid_pkg::E_W-1:0]  s1_err_ff;
   logic                             s1_int_en_ff;
   logic                             s1_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      s1_loop_ff   <= s0_loop;
      s1_err_ff    <= s0_err;
      s1_int_en_ff <= s0_int_en;
      s1_hit_ff    <= err_written_ff[s0_loop];
   end

   // ------------------------------------------------------------------
   // S1: error history with forwarding, write-back, differences
   // ------------------------------------------------------------------
   logic [ipid_pkg::ERR_MEM_W-1:0]   err_rd_data;
   logic [ipid_pkg::ERR_MEM_W-1:0]   err_wr_data;

   // Last error record written, for a request to the same loop that read
   // the RAM at the very edge of that write.
   logic                             fe_vld_ff;
   logic [ipid_pkg::LOOP_W-1:0]      fe_loop_ff;
   logic signed [ipid_pkg::E_W-1:0]  fe_e1_ff;
   logic signed [ipid_pkg::E_W-1:0]  fe_e2_ff;

   logic signed [ipid_pkg::E_W-1:0]  s1_e1;
   logic signed [ipid_pkg::E_W-1:0]  s1_e2;
   logic signed [ipid_pkg::DP_W-1:0] s1_dp;
   logic signed [ipid_pkg::DD_W-1:0] s1_dd;
   logic signed [ipid_pkg::E_W-1:0]  s1_ei;

   always_comb begin
      if (fe_vld_ff && (fe_loop_ff == s1_loop_ff)) begin
         s1_e1 = fe_e1_ff;
         s1_e2 = fe_e2_ff;
      end else if (s1_hit_ff) begin
         s1_e1 = err_rd_data[ipid_pkg::E_W-1:0];
         s1_e2 = err_rd_data[ipid_pkg::ERR_MEM_W-1:ipid_pkg::E_W];
      end else begin
         s1_e1 = '0;
         s1_e2 = '0;
      end
   end

   assign s1_dp = {s1_err_ff[ipid_pkg::E_W-1], s1_err_ff}
                - {s1_e1[ipid_pkg::E_W-1], s1_e1};
   assign s1_dd = {{2{s1_err_ff[ipid_pkg::E_W-1]}}, s1_err_ff}
                - {s1_e1[ipid_pkg::E_W-1], s1_e1, 1'b0}
                + {{2{s1_e2[ipid_pkg::E_W-1]}}, s1_e2};
   assign s1_ei = s1_int_en_ff ? s1_err_ff : '0;

   assign err_wr_data = {s1_e1, s1_err_ff};

   ipid_ram #(
      .WIDTH (ipid_pkg::ERR_MEM_W),
      .DEPTH (ipid_pkg::LOOPS)
   ) u_err_ram (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_loop_ff),
      .wr_data (err_wr_data),
      .rd_addr (s0_loop),
      .rd_data (err_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_vld_ff      <= 1'b0;
         err_written_ff <= '0;
      end else begin
         fe_vld_ff <= s1_vld_ff;
         if (s1_vld_ff) begin
            err_written_ff[s1_loop_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      fe_loop_ff <= s1_loop_ff;
      fe_e1_ff   <= s1_err_ff;
      fe_e2_ff   <= s1_e1;
   end

   logic [ipid_pkg::LOOP_W-1:0]      s2_loop_ff;
   logic signed [ipid_pkg::DP_W-1:0] s2_dp_ff;
   logic signed [ipid_pkg::DD_W-1:0] s2_dd_ff;
   logic signed [ipid_pkg::E_W-1:0]  s2_ei_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_loop_ff <= s1_loop_ff;
      s2_dp_ff   <= s1_dp;
      s2_dd_ff   <= s1_dd;
      s2_ei_ff   <= s1_ei;
   end

   // ------------------------------------------------------------------
   // S2: gain multiplications, each product registered
   // ------------------------------------------------------------------
   logic signed [ipid_pkg::PP_W-1:0] s2_pp;
   logic signed [ipid_pkg::PI_W-1:0] s2_pi;
   logic signed [ipid_pkg::PD_W-1:0] s2_pd;

   assign s2_pp = prop_gain_ff * s2_dp_ff;
   assign s2_pi = integral_gain_ff * s2_ei_ff;
   assign s2_pd = deriv_gain_ff * s2_dd_ff;

   logic [ipid_pkg::LOOP_W-1:0]      s3_loop_ff;
   logic signed [ipid_pkg::PP_W-1:0] s3_pp_ff;
   logic signed [ipid_pkg::PI_W-1:0] s3_pi_ff;
   logic signed [ipid_pkg::PD_W-1:0] s3_pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_loop_ff <= s2_loop_ff;
      s3_pp_ff   <= s2_pp;
      s3_pi_ff   <= s2_pi;
      s3_pd_ff   <= s2_pd;
   end

   // ------------------------------------------------------------------
   // S3: sum and truncation toward zero
   // ------------------------------------------------------------------
   logic signed [ipid_pkg::SUM_W-1:0] s3_sum;
   logic signed [ipid_pkg::SUM_W-1:0] s3_shifted;
   logic                              s3_round_up;
   logic signed [ipid_pkg::INC_W-1:0] s3_inc;

   assign s3_sum = ipid_pkg::SUM_W'(s3_pp_ff)
                 + ipid_pkg::SUM_W'(s3_pi_ff)
                 + ipid_pkg::SUM_W'(s3_pd_ff);

   // An arithmetic shift rounds toward minus infinity; a negative sum with
   // a non-zero fraction is moved up by one to round toward zero instead.
   assign s3_shifted  = s3_sum >>> ipid_pkg::GAIN_FRAC_BITS;
   assign s3_round_up = s3_sum[ipid_pkg::SUM_W-1] && (|s3_sum[ipid_pkg::GAIN_FRAC_BITS-1:0]);
   assign s3_inc      = s3_shifted[ipid_pkg::INC_W-1:0]
                      + $signed({{(ipid_pkg::INC_W-1){1'b0}}, s3_round_up});

   logic [ipid_pkg::LOOP_W-1:0]       s4_loop_ff;
   logic signed [ipid_pkg::INC_W-1:0] s4_inc_ff;
   logic                              s4_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_loop_ff <= s3_loop_ff;
      s4_inc_ff  <= s3_inc;
      s4_hit_ff  <= drv_written_ff[s3_loop_ff];
   end

   // ------------------------------------------------------------------
   // S4: drive update, clamp, write-back
   // ------------------------------------------------------------------
   logic [ipid_pkg::SMP_W-1:0]          drv_rd_data;
   logic                                fd_vld_ff;
   logic [ipid_pkg::LOOP_W-1:0]         fd_loop_ff;
   logic signed [ipid_pkg::SMP_W-1:0]   fd_drive_ff;

   logic signed [ipid_pkg::SMP_W-1:0]   s4_drive_old;
   logic signed [ipid_pkg::D_W-1:0]     s4_sum;
   logic signed [ipid_pkg::D_W-1:0]     s4_lim;
   logic signed [ipid_pkg::SMP_W-1:0]   s4_lim16;
   logic signed [ipid_pkg::SMP_W-1:0]   s4_drive;
   logic                                s4_clip;
   ipid_pkg::ipid_rsp_type              s4_rsp;

   always_comb begin
      if (fd_vld_ff && (fd_loop_ff == s4_loop_ff)) begin
         s4_drive_old = fd_drive_ff;
      end else if (s4_hit_ff) begin
         s4_drive_old = drv_rd_data;
      end else begin
         s4_drive_old = '0;
      end
   end

   assign s4_sum   = ipid_pkg::D_W'(s4_drive_old) + ipid_pkg::D_W'(s4_inc_ff);
   assign s4_lim   = $signed({{(ipid_pkg::D_W - ipid_pkg::LIM_W){1'b0}}, drive_limit_ff});
   assign s4_lim16 = $signed({1'b0, drive_limit_ff});

   // The clamped flag is raised only for a sum strictly outside the limit.
   always_comb begin
      if (s4_sum > s4_lim) begin
         s4_drive = s4_lim16;
         s4_clip  = 1'b1;
      end else if (s4_sum < -s4_lim) begin
         s4_drive = -s4_lim16;
         s4_clip  = 1'b1;
      end else begin
         s4_drive = s4_sum[ipid_pkg::SMP_W-1:0];
         s4_clip  = 1'b0;
      end
   end

   ipid_ram #(
      .WIDTH (ipid_pkg::SMP_W),
      .DEPTH (ipid_pkg::LOOPS)
   ) u_drv_ram (
      .clock   (clock),
      .wr_en   (s4_vld_ff),
      .wr_addr (s4_loop_ff),
      .wr_data (s4_drive),
      .rd_addr (s3_loop_ff),
      .rd_data (drv_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fd_vld_ff      <= 1'b0;
         drv_written_ff <= '0;
      end else begin
         fd_vld_ff <= s4_vld_ff;
         if (s4_vld_ff) begin
            drv_written_ff[s4_loop_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      fd_loop_ff  <= s4_loop_ff;
      fd_drive_ff <= s4_drive;
   end

   // ------------------------------------------------------------------
   // Output buffer and response channel
   // ------------------------------------------------------------------
   ipid_pkg::ipid_rsp_type rsp_head;

   assign s4_rsp.drive   = s4_drive;
   assign s4_rsp.clamped = s4_clip;

   ipid_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s4_vld_ff),
      .push_data  (s4_rsp),
      .pop        (rsp_tvalid && rsp_tready),
      .head_valid (rsp_tvalid),
      .head_data  (rsp_head),
      .count      (fifo_count)
   );

   assign rsp_tdata = rsp_head.drive;
   assign rsp_tuser = rsp_head.clamped;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`ifndef ASSERT_OFF
   // The admission rule must keep every transaction in flight a buffer slot.
   a_credit: assert property (@(posedge clock) disable iff (reset)
      inflight <= (ipid_pkg::RSP_CNT_W + 1)'(ipid_pkg::RSP_DEPTH))
      else $error("output buffer overcommitted");

   // A finished drive always lies within the configured limit.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> (s4_drive <= s4_lim16) && (s4_drive >= -s4_lim16))
      else $error("drive outside limit");

   // A clamped result sits exactly on one of the two limits.
   a_clip_on_limit: assert property (@(posedge clock) disable iff (reset)
      (s4_vld_ff && s4_clip) |-> (s4_drive == s4_lim16) || (s4_drive == -s4_lim16))
      else $error("clamped drive not on a limit");

   // Every transaction in S1 passes through S2 and S3 and is pushed into the output buffer from S4.
   a_push_follows: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> ##3 s4_vld_ff)
      else $error("transaction lost in pipeline");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multi-loop incremental PID core
// Walks a short table of directed transactions and register writes, then
// runs phases of random register settings and random control samples.
// Each accepted request is run through a local model of the controller and
// every response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  CSR_ADDR_W      = ipid_pkg::CSR_ADDR_W;
   localparam int  GAIN_W          = ipid_pkg::GAIN_W;
   localparam int  IDX_W           = ipid_pkg::IDX_W;
   localparam int  SMP_W           = ipid_pkg::SMP_W;
   localparam int  LIM_W           = ipid_pkg::LIM_W;
   localparam int  BAND_W          = ipid_pkg::BAND_W;
   localparam int  E_W             = ipid_pkg::E_W;
   localparam int  LOOPS           = ipid_pkg::LOOPS;
   localparam int  GAIN_FRAC_BITS  = ipid_pkg::GAIN_FRAC_BITS;

   localparam int  RSP_LATENCY     = 4;       // request edge to response offer
   localparam int  CYCLE_LIMIT     = 200000;
   localparam int  RANDOM_PHASES   = 14;
   localparam int  ITEMS_PER_PHASE = 125;
   localparam int  RSP_HOLD_CYCLES = 80;
   localparam int  PLAN_ROWS       = 31;
   localparam bit  PINNED          = 1'b1;    // expected result typed into the table
   localparam bit  PREDICTED       = 1'b0;    // expected result taken from the model

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One line of the directed table: either a request or a register write.
   typedef struct {
      row_kind_type            kind;
      logic [CSR_ADDR_W-1:0]   addr;
      logic [GAIN_W-1:0]       wdata;
      logic [IDX_W-1:0]        loop_sel;
      logic signed [SMP_W-1:0] setpoint;
      logic signed [SMP_W-1:0] measured;
      bit                      pinned;
      ipid_pkg::ipid_rsp_type  pin;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata  = '0;   // setpoint[15:0], measured[31:16]
   logic [2:0]            req_tuser  = '0;   // loop_index[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;         // drive[15:0]
   logic [0:0]            rsp_tuser;         // clamped[0]
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [GAIN_W-1:0]     csr_wdata  = '0;

   // Local copy of the controller: shared settings and per-loop history.
   logic signed [GAIN_W-1:0] gain_p;
   logic signed [GAIN_W-1:0] gain_i;
   logic signed [GAIN_W-1:0] gain_d;
   logic [LIM_W-1:0]         drive_cap;
   logic [BAND_W-1:0]        int_window;
   logic signed [E_W-1:0]    err_last   [LOOPS];
   logic signed [E_W-1:0]    err_prior  [LOOPS];
   logic signed [SMP_W-1:0]  drive_held [LOOPS];

   ipid_pkg::ipid_rsp_type pending_drives [$];
   stim_row_type           plan [PLAN_ROWS];
   int                     target [LOOPS];

   int  cycle_count    = 0;
   int  fail_count     = 0;
   int  requests_sent  = 0;
   int  results_seen   = 0;
   int  clamped_seen   = 0;
   int  writes_done    = 0;
   bit  idle_off       = 1'b0;
   int  hold_token     = 0;
   int  hold_seen      = 0;
   int  hold_left      = 0;

   incremental_pid_integral_separation_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Runaway guard: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Advances one loop by one sample and returns its new drive and clamp flag.
   // The sum of the three products is exact; the only rounding is the single
   // division by the fixed-point scale, which truncates toward zero.
   function automatic ipid_pkg::ipid_rsp_type advance_loop(
      input logic [IDX_W-1:0]        loop_sel,
      input logic signed [SMP_W-1:0] setpoint,
      input logic signed [SMP_W-1:0] measured);
      int unsigned            k;
      longint                 e, e1, e2, acc, sum, cap;
      ipid_pkg::ipid_rsp_type r;
      k   = int'(loop_sel) % LOOPS;
      e   = longint'(setpoint) - longint'(measured);
      e1  = longint'(err_last[k]);
      e2  = longint'(err_prior[k]);
      acc = longint'(gain_p) * (e - e1) + longint'(gain_d) * (e - 2 * e1 + e2);
      // The integral term only counts while the error sits inside the window.
      if ((e < 0 ? -e : e) <= longint'(int_window)) begin
         acc += longint'(gain_i) * e;
      end
      sum = longint'(drive_held[k]) + acc / (longint'(1) << GAIN_FRAC_BITS);
      cap = longint'(drive_cap);
      r.clamped = 1'b0;
      if (sum > cap) begin
         sum = cap;
         r.clamped = 1'b1;
      end else if (sum < -cap) begin
         sum = -cap;
         r.clamped = 1'b1;
      end
      err_prior[k]  = err_last[k];
      err_last[k]   = E_W'(e);
      drive_held[k] = SMP_W'(sum);
      r.drive       = SMP_W'(sum);
      return r;
   endfunction

   function automatic stim_row_type item_row(input logic [IDX_W-1:0] loop_sel,
                                             input logic signed [SMP_W-1:0] setpoint,
                                             input logic signed [SMP_W-1:0] measured,
                                             input bit pinned,
                                             input logic signed [SMP_W-1:0] drive,
                                             input bit clamped);
      stim_row_type row;
      row.kind        = ROW_ITEM;
      row.addr        = '0;
      row.wdata       = '0;
      row.loop_sel    = loop_sel;
      row.setpoint    = setpoint;
      row.measured    = measured;
      row.pinned      = pinned;
      row.pin.drive   = drive;
      row.pin.clamped = clamped;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [GAIN_W-1:0] wdata);
      stim_row_type row;
      row          = item_row('0, '0, '0, PREDICTED, '0, 1'b0);
      row.kind     = ROW_CSR;
      row.addr     = addr;
      row.wdata    = wdata;
      return row;
   endfunction

   // Gains lean towards realistic values within +/-3.0, with the extremes,
   // zero and raw random words mixed in.
   function automatic logic [GAIN_W-1:0] pick_gain();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return {1'b0, {(GAIN_W-1){1'b1}}};
      if (r < 20) return {1'b1, {(GAIN_W-1){1'b0}}};
      if (r < 30) return GAIN_W'($urandom);
      if (r < 40) return '0;
      return GAIN_W'(int'($urandom_range(6144)) - 3072);
   endfunction

   // The local settings follow a register write at once, which is safe because
   // writes only happen while nothing is in flight.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         ipid_pkg::CSR_PROP_GAIN:     gain_p     = data;
         ipid_pkg::CSR_INTEGRAL_GAIN: gain_i     = data;
         ipid_pkg::CSR_DERIV_GAIN:    gain_d     = data;
         ipid_pkg::CSR_DRIVE_LIMIT:   drive_cap  = data[LIM_W-1:0];
         ipid_pkg::CSR_INTEGRAL_BAND: int_window = data[BAND_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(posedge clock);
   endtask

   // Offers one request transaction, with a random gap in front unless idling
   // is switched off, and records the expected response once it is taken.
   task automatic send_item(input logic [IDX_W-1:0] loop_sel,
                            input logic signed [SMP_W-1:0] setpoint,
                            input logic signed [SMP_W-1:0] measured,
                            input bit pinned, input ipid_pkg::ipid_rsp_type pin);
      ipid_pkg::ipid_rsp_type predicted;
      while (!idle_off && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= loop_sel;
      req_tdata  <= {measured, setpoint};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = advance_loop(loop_sel, setpoint, measured);
      pending_drives.push_back(pinned ? pin : predicted);
      requests_sent++;
   endtask

   // Stops offering, waits until every response has come back and then lets the
   // pipeline settle.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_drives.size() != 0) begin
         @(posedge clock);
      end
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   // Response side: random back-pressure, a long hold-off when the stimulus
   // asks for one, and no idling at all during the quiet phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
         end
         rsp_tready <= (hold_left == 0) && (idle_off || $urandom_range(99) >= 14);
      end
   end

   // Response checker: every accepted response transaction is matched
   // against the oldest outstanding prediction.
   always @(posedge clock) begin
      ipid_pkg::ipid_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_drives.size() == 0) begin
            $error("response transaction with no request outstanding: drive %0d",
                   $signed(rsp_tdata));
            fail_count++;
         end else begin
            want = pending_drives.pop_front();
            if (rsp_tdata !== want.drive) begin
               $error("drive mismatch: expected %0d, actual %0d",
                      want.drive, $signed(rsp_tdata));
               fail_count++;
            end
            if (rsp_tuser[0] !== want.clamped) begin
               $error("clamped mismatch: expected %0b, actual %0b",
                      want.clamped, rsp_tuser[0]);
               fail_count++;
            end
            results_seen++;
            if (rsp_tuser[0] === 1'b1) begin
               clamped_seen++;
            end
         end
      end
   end

   initial begin
      int                      noise, spread;
      logic [IDX_W-1:0]        lp;
      logic signed [SMP_W-1:0] sp, ms;
      logic [GAIN_W-1:0]       word;

      // Local model starts from the reset state of the core.
      gain_p     = '0;
      gain_i     = '0;
      gain_d     = '0;
      drive_cap  = ipid_pkg::DRIVE_LIMIT_RST;
      int_window = ipid_pkg::INTEGRAL_BAND_RST;
      for (int k = 0; k < LOOPS; k++) begin
         err_last[k]   = '0;
         err_prior[k]  = '0;
         drive_held[k] = '0;
      end

      // Directed table. Typed results are the ones that follow directly:
      // zero gains after reset, unity gain on a fresh loop, a stored drive
      // above a lowered limit, a sum landing exactly on the limit, and the
      // truncation toward zero of a negative half step.
      plan = '{
         item_row(3'd0,  32767, -32768, PINNED,    0, 1'b0),
         item_row(3'd7, -32768,  32767, PINNED,    0, 1'b0),
         csr_row(ipid_pkg::CSR_PROP_GAIN, 20'd1024),
         item_row(3'd1,    100,      0, PINNED,  100, 1'b0),
         item_row(3'd1,    100,      0, PREDICTED, 0, 1'b0),
         csr_row(ipid_pkg::CSR_DRIVE_LIMIT, 20'd50),
         item_row(3'd1,    100,      0, PINNED,   50, 1'b1),
         item_row(3'd2,     50,      0, PINNED,   50, 1'b0),
         item_row(3'd2,    -50,      0, PREDICTED, 0, 1'b0),
         csr_row(ipid_pkg::CSR_PROP_GAIN, 20'd512),
         item_row(3'd4,      0,      3, PINNED,   -1, 1'b0),
         item_row(3'd4,      0,     -3, PREDICTED, 0, 1'b0),
         csr_row(ipid_pkg::CSR_INTEGRAL_GAIN, 20'd1024),
         csr_row(ipid_pkg::CSR_INTEGRAL_BAND, 20'd0),
         item_row(3'd5,      7,      7, PREDICTED, 0, 1'b0),
         item_row(3'd5,      8,      7, PREDICTED, 0, 1'b0),
         csr_row(ipid_pkg::CSR_PROP_GAIN, 20'h7FFFF),
         csr_row(ipid_pkg::CSR_INTEGRAL_GAIN, 20'h80000),
         csr_row(ipid_pkg::CSR_DERIV_GAIN, 20'h80000),
         csr_row(ipid_pkg::CSR_DRIVE_LIMIT, 20'd32767),
         csr_row(ipid_pkg::CSR_INTEGRAL_BAND, 20'd65535),
         item_row(3'd3,  32767, -32768, PREDICTED, 0, 1'b0),
         item_row(3'd3, -32768,  32767, PREDICTED, 0, 1'b0),
         item_row(3'd3, -32768,  32767, PREDICTED, 0, 1'b0),
         item_row(3'd6,      0,      0, PREDICTED, 0, 1'b0),
         csr_row(ipid_pkg::CSR_DRIVE_LIMIT, 20'd0),
         item_row(3'd6,   1000,      0, PREDICTED, 0, 1'b0),
         item_row(3'd0,      0,      0, PREDICTED, 0, 1'b0),
         csr_row(ipid_pkg::CSR_DERIV_GAIN, 20'h7FFFF),
         item_row(3'd7, -32768, -32768, PREDICTED, 0, 1'b0),
         item_row(3'd2,  32767,  32767, PREDICTED, 0, 1'b0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < PLAN_ROWS; n++) begin
         if (plan[n].kind == ROW_CSR) begin
            wait_drain();
            csr_write(plan[n].addr, plan[n].wdata);
         end else begin
            send_item(plan[n].loop_sel, plan[n].setpoint, plan[n].measured,
                      plan[n].pinned, plan[n].pin);
         end
      end

      // Random phases. Each starts from an idle core with fresh settings and
      // fresh per-loop setpoints; most samples track the setpoint with
      // noise of varying size so that the integral window is crossed both
      // ways, and the rest are raw full-range words.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drain();
         // The first two phases run without any random idling; the second
         // of them also holds the response side off for a long stretch so
         // that the output buffer fills and the request side stalls.
         idle_off <= (phase < 2);
         csr_write(ipid_pkg::CSR_PROP_GAIN, pick_gain());
         csr_write(ipid_pkg::CSR_INTEGRAL_GAIN, pick_gain());
         csr_write(ipid_pkg::CSR_DERIV_GAIN, pick_gain());
         word = ($urandom_range(99) < 25) ? GAIN_W'($urandom) : '0;
         case ($urandom_range(3))
            0:       word[LIM_W-1:0] = '0;
            1:       word[LIM_W-1:0] = '1;
            2:       word[LIM_W-1:0] = LIM_W'($urandom_range(3000));
            default: word[LIM_W-1:0] = LIM_W'($urandom);
         endcase
         csr_write(ipid_pkg::CSR_DRIVE_LIMIT, word);
         word = ($urandom_range(99) < 25) ? GAIN_W'($urandom) : '0;
         case ($urandom_range(3))
            0:       word[BAND_W-1:0] = '0;
            1:       word[BAND_W-1:0] = '1;
            2:       word[BAND_W-1:0] = BAND_W'($urandom_range(100));
            default: word[BAND_W-1:0] = BAND_W'($urandom);
         endcase
         csr_write(ipid_pkg::CSR_INTEGRAL_BAND, word);
         // Indexes beyond the last register are unmapped and must leave the
         // settings untouched.
         if ($urandom_range(99) < 30) begin
            csr_write(CSR_ADDR_W'(ipid_pkg::CSR_INTEGRAL_BAND)
                      + CSR_ADDR_W'(1 + $urandom_range(2)),
                      GAIN_W'($urandom));
         end
         for (int k = 0; k < LOOPS; k++) begin
            target[k] = int'($urandom_range(40000)) - 20000;
         end
         if (phase == 1) begin
            hold_token <= hold_token + 1;
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through one phase the sender waits for every response.
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
               wait_drain();
            end
            // Now and then one loop sees a step in its setpoint.
            if (n % 40 == 39) begin
               target[$urandom_range(LOOPS - 1)] = int'($urandom_range(40000)) - 20000;
            end
            lp = IDX_W'($urandom);
            if ($urandom_range(99) < 80) begin
               case ($urandom_range(2))
                  0:       spread = 3;
                  1:       spread = 60;
                  default: spread = 600;
               endcase
               noise = int'($urandom_range(2 * spread)) - spread;
               sp    = SMP_W'(target[lp]);
               ms    = SMP_W'(target[lp] - noise);
            end else begin
               sp = SMP_W'($urandom);
               ms = SMP_W'($urandom);
            end
            send_item(lp, sp, ms, PREDICTED, '0);
         end
      end

      wait_drain();

      $display("Checked %0d drive results from %0d request transactions over %0d register writes.",
               results_seen, requests_sent, writes_done);
      $display("%0d results were clamped; %0d mismatches were found.", clamped_seen, fail_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
